/* rtl/dpme_pkg.sv */
// ----------------------------------------------------------------------------
// dpme_pkg
// Shared types and constants for the DiSEqC pulse-width message encoder.
// ----------------------------------------------------------------------------
package dpme_pkg;

    // Register indexes on the configuration port
    localparam logic [2:0] REG_SHORT_US     = 3'd0;
    localparam logic [2:0] REG_LONG_US      = 3'd1;
    localparam logic [2:0] REG_FRAME_GAP_US = 3'd2;
    localparam logic [2:0] REG_BURST_US     = 3'd3;
    localparam logic [2:0] REG_POST_WAIT_US = 3'd4;

    // Register reset values in microseconds
    localparam logic [15:0] RST_SHORT_US     = 16'd500;
    localparam logic [15:0] RST_LONG_US      = 16'd1000;
    localparam logic [15:0] RST_FRAME_GAP_US = 16'd16000;
    localparam logic [15:0] RST_BURST_US     = 16'd12500;
    localparam logic [15:0] RST_POST_WAIT_US = 16'd20000;

    // Burst mode codes
    localparam logic [1:0] BURST_NONE = 2'd0;
    localparam logic [1:0] BURST_TONE = 2'd1;
    localparam logic [1:0] BURST_BYTE = 2'd2;

    // Byte sent modulated for a modulated burst
    localparam logic [7:0] BURST_DATA = 8'hFF;

    // Index of the parity bit within a byte's bit sequence
    localparam logic [3:0] PARITY_IDX = 4'd8;

    // Action codes
    localparam logic ACT_MESSAGE = 1'b0;
    localparam logic ACT_BURST   = 1'b1;

    // Control of the shared shift and parity unit
    typedef struct packed {
        logic       load;
        logic [7:0] load_val;
        logic       shift;
        logic       sel_parity;
    } shift_ctrl_t;

endpackage

/* rtl/diseqc_pwm_message_encoder.sv */
// ----------------------------------------------------------------------------
// diseqc_pwm_message_encoder
// Expands DiSEqC message bytes and tone bursts into timed line segments.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+-------------------------------
//  in      | input     | in_valid / in_stall  | action data_byte first_byte
//          |           |                      | last_byte burst_mode
//  out     | output    | out_valid/out_stall  | line_level duration_us
//          |           |                      | end_of_run
//  cfg     | input     | cfg_valid/cfg_ready  | cfg_index cfg_data
//
// An item is taken while the sequencer is idle; the sequencer then emits one
// segment per cycle into the output register unless the output stalls, N
// segments per item, with N from 2 to 39, bits from the shared shift/parity
// unit. Output stall holds the sequencer; in_stall stays high until the last
// segment of the item has been handed to the output register.
// Reset restores the register defaults and empties the output register.
module diseqc_pwm_message_encoder
(
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        action,
    input  logic [7:0]  data_byte,
    input  logic        first_byte,
    input  logic        last_byte,
    input  logic [1:0]  burst_mode,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic        line_level,
    output logic [15:0] duration_us,
    output logic        end_of_run,
    // configuration channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_LEAD  = 6'b000010,
        ST_BITS  = 6'b000100,
        ST_TAIL  = 6'b001000,
        ST_BURST = 6'b010000,
        ST_POST  = 6'b100000
    } state_t;

    state_t      state_reg;
    state_t      state_next;
    logic [3:0]  cnt_reg;
    logic [3:0]  cnt_next;
    logic        half_reg;
    logic        half_next;
    logic        bbits_reg;
    logic        bbits_next;
    logic        act_reg;
    logic        act_next;
    logic        last_reg;
    logic        last_next;
    logic [1:0]  mode_reg;
    logic [1:0]  mode_next;

    logic [15:0] short_reg;
    logic [15:0] long_reg;
    logic [15:0] gap_reg;
    logic [15:0] burst_reg;
    logic [15:0] post_reg;

    logic        out_valid_reg;
    logic        level_reg;
    logic [15:0] dur_reg;
    logic        eor_reg;

    logic        in_accept;
    logic        adv;
    logic        seg_level;
    logic [15:0] seg_dur;
    logic        seg_eor;
    logic        cur_bit;

    dpme_pkg::shift_ctrl_t sh_ctrl;

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            short_reg <= dpme_pkg::RST_SHORT_US;
            long_reg  <= dpme_pkg::RST_LONG_US;
            gap_reg   <= dpme_pkg::RST_FRAME_GAP_US;
            burst_reg <= dpme_pkg::RST_BURST_US;
            post_reg  <= dpme_pkg::RST_POST_WAIT_US;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dpme_pkg::REG_SHORT_US:     short_reg <= cfg_data;
                dpme_pkg::REG_LONG_US:      long_reg  <= cfg_data;
                dpme_pkg::REG_FRAME_GAP_US: gap_reg   <= cfg_data;
                dpme_pkg::REG_BURST_US:     burst_reg <= cfg_data;
                dpme_pkg::REG_POST_WAIT_US: post_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Handshake
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_accept = in_valid && !in_stall;
    assign adv       = (state_reg != ST_IDLE) && (!out_valid_reg || !out_stall);

    // Shared shift and parity unit
    dpme_shifter u_shifter
    (
        .clk     (clk),
        .ctrl    (sh_ctrl),
        .bit_out (cur_bit)
    );

    // Sequencer: pick the segment and the next step
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        half_next        = half_reg;
        bbits_next       = bbits_reg;
        act_next         = act_reg;
        last_next        = last_reg;
        mode_next        = mode_reg;
        seg_level        = 1'b0;
        seg_dur          = gap_reg;
        seg_eor          = 1'b0;
        sh_ctrl.load     = 1'b0;
        sh_ctrl.load_val = data_byte;
        sh_ctrl.shift    = 1'b0;
        sh_ctrl.sel_parity = (cnt_reg == dpme_pkg::PARITY_IDX);

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    act_next     = action;
                    last_next    = last_byte;
                    mode_next    = burst_mode;
                    cnt_next     = 4'd0;
                    half_next    = 1'b0;
                    bbits_next   = 1'b0;
                    sh_ctrl.load = 1'b1;
                    if ((action == dpme_pkg::ACT_BURST) || first_byte)
                        state_next = ST_LEAD;
                    else
                        state_next = ST_BITS;
                end
            end
            ST_LEAD:
            begin
                seg_level = 1'b0;
                seg_dur   = gap_reg;
                if (adv)
                    state_next = (act_reg == dpme_pkg::ACT_BURST) ? ST_TAIL : ST_BITS;
            end
            ST_BITS:
            begin
                seg_level = ~half_reg;
                seg_dur   = (cur_bit ^ half_reg) ? short_reg : long_reg;
                if ((cnt_reg == dpme_pkg::PARITY_IDX) && half_reg && !bbits_reg
                    && !last_reg)
                    seg_eor = 1'b1;
                if (adv)
                begin
                    half_next = ~half_reg;
                    if (half_reg)
                    begin
                        if (cnt_reg == dpme_pkg::PARITY_IDX)
                        begin
                            if (bbits_reg)
                                state_next = ST_POST;
                            else if (last_reg)
                                state_next = ST_TAIL;
                            else
                                state_next = ST_IDLE;
                        end
                        else
                        begin
                            sh_ctrl.shift = 1'b1;
                            cnt_next      = cnt_reg + 4'd1;
                        end
                    end
                end
            end
            ST_TAIL:
            begin
                seg_level = 1'b0;
                seg_dur   = gap_reg;
                seg_eor   = (mode_reg != dpme_pkg::BURST_TONE) &&
                            (mode_reg != dpme_pkg::BURST_BYTE);
                if (adv)
                begin
                    case (mode_reg)
                        dpme_pkg::BURST_TONE: state_next = ST_BURST;
                        dpme_pkg::BURST_BYTE:
                        begin
                            state_next       = ST_BITS;
                            cnt_next         = 4'd0;
                            half_next        = 1'b0;
                            bbits_next       = 1'b1;
                            sh_ctrl.load     = 1'b1;
                            sh_ctrl.load_val = dpme_pkg::BURST_DATA;
                        end
                        default: state_next = ST_IDLE;
                    endcase
                end
            end
            ST_BURST:
            begin
                seg_level = 1'b1;
                seg_dur   = burst_reg;
                if (adv)
                    state_next = ST_POST;
            end
            ST_POST:
            begin
                seg_level = 1'b0;
                seg_dur   = post_reg;
                seg_eor   = 1'b1;
                if (adv)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cnt_reg   <= 4'd0;
            half_reg  <= 1'b0;
            bbits_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            half_reg  <= half_next;
            bbits_reg <= bbits_next;
        end
    end

    // Hold item flags
    always_ff @(posedge clk)
    begin
        act_reg  <= act_next;
        last_reg <= last_next;
        mode_reg <= mode_next;
    end

    // Output register: load a segment on advance, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (!out_stall)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            level_reg <= seg_level;
            dur_reg   <= seg_dur;
            eor_reg   <= seg_eor;
        end
    end

    assign out_valid   = out_valid_reg;
    assign line_level  = level_reg;
    assign duration_us = dur_reg;
    assign end_of_run  = eor_reg;

`ifndef SYNTHESIS
    // Block goes busy right after taking an item
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> in_stall)
        else $error("encoder not busy after accepting an item");

    // Bit counter never runs past the parity bit
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BITS) |-> (cnt_reg <= dpme_pkg::PARITY_IDX))
        else $error("bit counter out of range");

    // Every run ends on a low segment
    a_run_ends_low: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && end_of_run) |-> !line_level)
        else $error("run ended on a high segment");
`endif

endmodule

/* rtl/dpme_shifter.sv */
// ----------------------------------------------------------------------------
// dpme_shifter
// Byte shift register with running odd parity; presents the current bit,
// MSB first, then the parity bit.
// ----------------------------------------------------------------------------
module dpme_shifter
(
    input  logic                 clk,
    input  dpme_pkg::shift_ctrl_t ctrl,
    output logic                 bit_out
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;
    logic       par_reg;
    logic       par_next;

    // Load a new byte or advance one bit, folding it into the parity
    always_comb
    begin
        byte_next = byte_reg;
        par_next  = par_reg;
        if (ctrl.load)
        begin
            byte_next = ctrl.load_val;
            par_next  = 1'b1;
        end
        else if (ctrl.shift)
        begin
            byte_next = {byte_reg[6:0], 1'b0};
            par_next  = par_reg ^ byte_reg[7];
        end
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
        par_reg  <= par_next;
    end

    // Select data bit or parity bit
    assign bit_out = ctrl.sel_parity ? par_reg : byte_reg[7];

endmodule

/* bench/diseqc_pwm_message_encoder_tb.sv */
// ----------------------------------------------------------------------------
// diseqc_pwm_message_encoder_tb
// Self-checking bench for the DiSEqC pulse-width message encoder. Message
// bytes, multi-byte messages and burst-only transactions are pushed through
// the input channel under several register settings, and every line segment
// leaving the block is compared against a segment list computed in the bench.
// Both channels see random idle and stall bursts except in the closing phase.
// ----------------------------------------------------------------------------
module diseqc_pwm_message_encoder_tb;

    timeunit 1ns;
    timeprecision 1ps;

    // Reserved burst code, sent as no burst
    localparam logic [1:0] BURST_UNUSED = 2'd3;

    typedef struct packed {
        logic        level;
        logic [15:0] dur;
        logic        eor;
    } segment_t;

    // ------------------------------------------------------------------------
    // Segment scoreboard: expands each accepted transaction into line segments
    // ------------------------------------------------------------------------
    class segment_scoreboard;
        logic [15:0] short_us;
        logic [15:0] long_us;
        logic [15:0] gap_us;
        logic [15:0] burst_us;
        logic [15:0] post_us;
        segment_t    pending_segments[$];
        int          mismatches;
        int          items_seen;
        int          segments_seen;

        function new();
            short_us      = dpme_pkg::RST_SHORT_US;
            long_us       = dpme_pkg::RST_LONG_US;
            gap_us        = dpme_pkg::RST_FRAME_GAP_US;
            burst_us      = dpme_pkg::RST_BURST_US;
            post_us       = dpme_pkg::RST_POST_WAIT_US;
            mismatches    = 0;
            items_seen    = 0;
            segments_seen = 0;
        endfunction

        // Mirror a register write; unknown indexes are dropped
        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                dpme_pkg::REG_SHORT_US:     short_us = val;
                dpme_pkg::REG_LONG_US:      long_us  = val;
                dpme_pkg::REG_FRAME_GAP_US: gap_us   = val;
                dpme_pkg::REG_BURST_US:     burst_us = val;
                dpme_pkg::REG_POST_WAIT_US: post_us  = val;
                default: ;
            endcase
        endfunction

        function void add_segment(logic lvl, logic [15:0] d);
            segment_t s;
            s.level = lvl;
            s.dur   = d;
            s.eor   = 1'b0;
            pending_segments.push_back(s);
        endfunction

        // One bit: high then low, short/long swapped by the bit value
        function void add_bit(logic b);
            add_segment(1'b1, b ? short_us : long_us);
            add_segment(1'b0, b ? long_us : short_us);
        endfunction

        // MSB first, then odd parity
        function void add_byte(logic [7:0] by);
            for (int i = 7; i >= 0; i--)
                add_bit(by[i]);
            add_bit(~(^by));
        endfunction

        function void add_tail(logic [1:0] mode);
            add_segment(1'b0, gap_us);
            if (mode == dpme_pkg::BURST_TONE)
            begin
                add_segment(1'b1, burst_us);
                add_segment(1'b0, post_us);
            end
            else if (mode == dpme_pkg::BURST_BYTE)
            begin
                add_byte(dpme_pkg::BURST_DATA);
                add_segment(1'b0, post_us);
            end
        endfunction

        // Note an accepted input transaction and queue its segments
        function void encode_item(logic act, logic [7:0] d, logic f, logic l,
                                  logic [1:0] mode);
            segment_t s;
            if (act == dpme_pkg::ACT_BURST)
            begin
                add_segment(1'b0, gap_us);
                add_tail(mode);
            end
            else
            begin
                if (f)
                    add_segment(1'b0, gap_us);
                add_byte(d);
                if (l)
                    add_tail(mode);
            end
            // Mark the last segment of this transaction
            s = pending_segments.pop_back();
            s.eor = 1'b1;
            pending_segments.push_back(s);
            items_seen++;
        endfunction

        // Compare one output transaction with the oldest queued segment
        function void check_segment(logic lvl, logic [15:0] d, logic e);
            segment_t s;
            segments_seen++;
            if (pending_segments.size() == 0)
            begin
                $display("%0t: unexpected segment level=%0d duration=%0d end=%0d",
                         $time, lvl, d, e);
                mismatches++;
                return;
            end
            s = pending_segments.pop_front();
            if (lvl !== s.level)
            begin
                $display("%0t: line_level mismatch expected %0d actual %0d",
                         $time, s.level, lvl);
                mismatches++;
            end
            if (d !== s.dur)
            begin
                $display("%0t: duration_us mismatch expected %0d actual %0d",
                         $time, s.dur, d);
                mismatches++;
            end
            if (e !== s.eor)
            begin
                $display("%0t: end_of_run mismatch expected %0d actual %0d",
                         $time, s.eor, e);
                mismatches++;
            end
        endfunction

        function int pending();
            return pending_segments.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        action;
    logic [7:0]  data_byte;
    logic        first_byte;
    logic        last_byte;
    logic [1:0]  burst_mode;
    logic        out_valid;
    logic        out_stall;
    logic        line_level;
    logic [15:0] duration_us;
    logic        end_of_run;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    segment_scoreboard segments;
    logic quiet;
    int   hold_cnt;
    logic stalling;
    int   settings_used;

    diseqc_pwm_message_encoder dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .data_byte   (data_byte),
        .first_byte  (first_byte),
        .last_byte   (last_byte),
        .burst_mode  (burst_mode),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .line_level  (line_level),
        .duration_us (duration_us),
        .end_of_run  (end_of_run),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Stall the output in random bursts; hold it open in the quiet phase
    always @(negedge clk)
    begin
        if (quiet)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (hold_cnt == 0)
            begin
                stalling = ($urandom_range(0, 2) == 0);
                hold_cnt = stalling ? int'($urandom_range(1, 15))
                                    : int'($urandom_range(1, 30));
            end
            hold_cnt--;
            out_stall <= stalling;
        end
    end

    // Check every accepted output transaction
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            segments.check_segment(line_level, duration_us, end_of_run);
    end

    // Drive one input transaction and wait for it to be taken
    task automatic push_item(input logic act, input logic [7:0] d, input logic f,
                             input logic l, input logic [1:0] mode);
        int gap;
        @(negedge clk);
        action     = act;
        data_byte  = d;
        first_byte = f;
        last_byte  = l;
        burst_mode = mode;
        in_valid   = 1'b1;
        do @(posedge clk); while (in_stall);
        segments.encode_item(act, d, f, l, mode);
        // Drop valid for a random burst now and then
        if (!quiet && $urandom_range(0, 2) == 0)
        begin
            gap = int'($urandom_range(1, 15));
            @(negedge clk);
            in_valid = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Write one register through the configuration channel
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge clk); while (!cfg_ready);
        segments.write_reg(idx, val);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic program_regs(input logic [15:0] s, input logic [15:0] l,
                                input logic [15:0] g, input logic [15:0] b,
                                input logic [15:0] p);
        write_reg(dpme_pkg::REG_SHORT_US, s);
        write_reg(dpme_pkg::REG_LONG_US, l);
        write_reg(dpme_pkg::REG_FRAME_GAP_US, g);
        write_reg(dpme_pkg::REG_BURST_US, b);
        write_reg(dpme_pkg::REG_POST_WAIT_US, p);
        settings_used++;
    endtask

    // Wait until every queued segment has come out and the block is idle
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (segments.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Mostly well-formed messages with random content, some noise
    task automatic random_traffic(input int target);
        int done;
        int n;
        int pick;
        logic [1:0] mode;
        done = 0;
        while (done < target)
        begin
            pick = int'($urandom_range(0, 9));
            if (pick < 8)
            begin
                n    = int'($urandom_range(1, 6));
                mode = 2'($urandom_range(0, 3));
                for (int k = 0; k < n; k++)
                    push_item(dpme_pkg::ACT_MESSAGE, 8'($urandom_range(0, 255)),
                              k == 0, k == n - 1, mode);
                done += n;
            end
            else if (pick == 8)
            begin
                push_item(dpme_pkg::ACT_BURST, 8'($urandom), 1'($urandom),
                          1'($urandom), 2'($urandom));
                done++;
            end
            else
            begin
                push_item(1'($urandom), 8'($urandom), 1'($urandom), 1'($urandom),
                          2'($urandom));
                done++;
            end
        end
    endtask

    // Watchdog
    initial
    begin
        #10_000_000;
        $display("diseqc_pwm_message_encoder verification failed");
        $finish;
    end

    initial
    begin
        segments      = new();
        quiet         = 1'b0;
        hold_cnt      = 0;
        stalling      = 1'b0;
        settings_used = 1;
        rst_n         = 1'b0;
        in_valid      = 1'b0;
        action        = dpme_pkg::ACT_MESSAGE;
        data_byte     = 8'h00;
        first_byte    = 1'b0;
        last_byte     = 1'b0;
        burst_mode    = dpme_pkg::BURST_NONE;
        out_stall     = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = dpme_pkg::REG_SHORT_US;
        cfg_data      = 16'h0000;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed cases on the reset register values
        push_item(dpme_pkg::ACT_MESSAGE, 8'h00, 1'b1, 1'b1, dpme_pkg::BURST_NONE);
        push_item(dpme_pkg::ACT_MESSAGE, 8'hFF, 1'b1, 1'b1, dpme_pkg::BURST_TONE);
        push_item(dpme_pkg::ACT_MESSAGE, 8'hA5, 1'b1, 1'b1, dpme_pkg::BURST_BYTE);
        push_item(dpme_pkg::ACT_MESSAGE, 8'h5A, 1'b1, 1'b1, BURST_UNUSED);
        push_item(dpme_pkg::ACT_MESSAGE, 8'h01, 1'b1, 1'b0, dpme_pkg::BURST_TONE);
        push_item(dpme_pkg::ACT_MESSAGE, 8'h80, 1'b0, 1'b0, dpme_pkg::BURST_BYTE);
        push_item(dpme_pkg::ACT_MESSAGE, 8'h7F, 1'b0, 1'b1, dpme_pkg::BURST_TONE);
        push_item(dpme_pkg::ACT_BURST, 8'h00, 1'b0, 1'b0, dpme_pkg::BURST_NONE);
        push_item(dpme_pkg::ACT_BURST, 8'hFF, 1'b1, 1'b1, dpme_pkg::BURST_TONE);
        push_item(dpme_pkg::ACT_BURST, 8'h3C, 1'b1, 1'b0, dpme_pkg::BURST_BYTE);
        push_item(dpme_pkg::ACT_BURST, 8'hC3, 1'b0, 1'b1, BURST_UNUSED);
        push_item(dpme_pkg::ACT_MESSAGE, 8'hC3, 1'b0, 1'b0, dpme_pkg::BURST_NONE);
        push_item(dpme_pkg::ACT_MESSAGE, 8'h3C, 1'b0, 1'b1, dpme_pkg::BURST_BYTE);
        push_item(dpme_pkg::ACT_MESSAGE, 8'hE0, 1'b1, 1'b0, dpme_pkg::BURST_NONE);
        random_traffic(50);
        drain();

        // Largest durations; out-of-range indexes must be ignored
        program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        write_reg(3'd5, 16'h0000);
        write_reg(3'd6, 16'hFFFF);
        write_reg(3'd7, 16'($urandom));
        random_traffic(60);
        drain();

        // Smallest nonzero durations
        program_regs(16'd1, 16'd1, 16'd1, 16'd1, 16'd1);
        random_traffic(60);
        drain();

        // Zero registers give zero-length segments
        program_regs(16'd0, 16'($urandom), 16'd0, 16'd0, 16'($urandom));
        random_traffic(60);
        drain();

        // Random settings, no idling on either side
        program_regs(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
        quiet = 1'b1;
        random_traffic(70);
        drain();
        repeat (10) @(posedge clk);

        $display("Ran %0d input transactions and %0d line segments",
                 segments.items_seen, segments.segments_seen);
        $display("across %0d register settings, incl. burst-only, unused burst code, zero length.",
                 settings_used);
        if (segments.mismatches == 0 && segments.pending() == 0)
            $display("diseqc_pwm_message_encoder verification clean");
        else
            $display("diseqc_pwm_message_encoder verification failed");
        $finish;
    end

endmodule

/* files.f */
rtl/dpme_pkg.sv
rtl/dpme_shifter.sv
rtl/diseqc_pwm_message_encoder.sv
bench/diseqc_pwm_message_encoder_tb.sv
